### design/ps2kc_pkg.sv
package ps2kc_pkg;

    localparam int REPLY_DEPTH = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_DUAL_CHANNEL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEYBOARD_ID  = 1'd1;

    localparam logic       DUAL_CHANNEL_RST = 1'b1;
    localparam logic [7:0] KEYBOARD_ID_RST  = 8'h83;
    localparam logic [7:0] CONFIG_BYTE_RST  = 8'h20;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_STATUS_READ = 2'd0;
    localparam kind_t KIND_DATA_READ   = 2'd1;
    localparam kind_t KIND_CMD_WRITE   = 2'd2;
    localparam kind_t KIND_DATA_WRITE  = 2'd3;

    localparam logic [7:0] CMD_READ_CONFIG  = 8'h20;
    localparam logic [7:0] CMD_WRITE_CONFIG = 8'h60;
    localparam logic [7:0] CMD_SELF_TEST    = 8'hAA;
    localparam logic [7:0] CMD_PORT1_TEST   = 8'hAB;
    localparam logic [7:0] CMD_PORT1_OFF    = 8'hAD;
    localparam logic [7:0] CMD_PORT2_OFF    = 8'hA7;
    localparam logic [7:0] CMD_PORT1_ON     = 8'hAE;

    localparam logic [7:0] KBD_RESET        = 8'hFF;
    localparam logic [7:0] KBD_SCAN_ON      = 8'hF4;
    localparam logic [7:0] KBD_SCAN_OFF     = 8'hF5;
    localparam logic [7:0] KBD_IDENTIFY     = 8'hF2;

    localparam logic [7:0] REPLY_ACK        = 8'hFA;
    localparam logic [7:0] REPLY_TEST_PASS  = 8'hAA;
    localparam logic [7:0] REPLY_ID_FIRST   = 8'hAB;
    localparam logic [7:0] REPLY_RESEND     = 8'hFE;
    localparam logic [7:0] REPLY_CTRL_OK    = 8'h55;
    localparam logic [7:0] REPLY_PORT_OK    = 8'h00;

    localparam int CFG_DUAL_BIT = 5;
    localparam int MAX_PUSH     = 3;

endpackage

### design/ps2kc_if.sv
interface ps2kc_req_if;
    logic                valid;
    logic                ready;
    ps2kc_pkg::kind_t    kind;
    logic [7:0]          write_byte;

    modport source (output valid, output kind, output write_byte, input ready);
    modport sink   (input valid, input kind, input write_byte, output ready);
endinterface

interface ps2kc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       dropped;

    modport source (output valid, output read_byte, output dropped, input ready);
    modport sink   (input valid, input read_byte, input dropped, output ready);
endinterface

### design/ps2_keyboard_controller_top.sv
// Keyboard controller with one attached keyboard. Each request is one bus access (status
// read, data read, command write, data write) and yields exactly one response in the cycle
// after acceptance. A new request is taken every cycle while the response register is
// empty or being drained, so the sustained rate is one access per clock; the only thing
// that holds requests back is a stalled response. Reply bytes queue in a circular buffer
// of REPLY_DEPTH entries that takes up to three bytes per access; bytes that do not fit
// are dropped and flagged in the response. Configuration writes apply at the next access.
module ps2_keyboard_controller_top #(
    parameter int REPLY_DEPTH = ps2kc_pkg::REPLY_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ps2kc_req_if.sink                          req,
    ps2kc_rsp_if.source                        rsp,
    input  logic                               cfg_we,
    input  logic [ps2kc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ps2kc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int PTR_W = $clog2(REPLY_DEPTH);
    localparam int CNT_W = $clog2(REPLY_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int NPUSH = ps2kc_pkg::MAX_PUSH;

    logic [7:0]       fifo_mem [REPLY_DEPTH];
    logic [PTR_W-1:0] head_reg,  head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       last_read_reg, last_read_next;
    logic [7:0]       config_byte_reg, config_byte_next;
    logic             await_config_reg, await_config_next;
    logic [1:0]       port_en_reg, port_en_next;
    logic             scanning_reg, scanning_next;
    logic             dual_channel_reg;
    logic [7:0]       keyboard_id_reg;

    logic             rsp_valid_reg;
    logic [7:0]       read_byte_reg;
    logic             dropped_reg;

    logic             accept;
    logic             pop;
    logic [1:0]       push_n;
    logic [7:0]       push_byte [NPUSH];
    logic [NPUSH-1:0] push_fits;
    logic [PTR_W-1:0] push_idx  [NPUSH];
    logic [CNT_W-1:0] pushed;
    logic             drop;
    logic [7:0]       rd_byte;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        pop               = 1'b0;
        push_n            = 2'd0;
        push_byte[0]      = 8'h00;
        push_byte[1]      = 8'h00;
        push_byte[2]      = 8'h00;
        rd_byte           = 8'h00;
        last_read_next    = last_read_reg;
        config_byte_next  = config_byte_reg;
        await_config_next = await_config_reg;
        port_en_next      = port_en_reg;
        scanning_next     = scanning_reg;
        case (req.kind)
            ps2kc_pkg::KIND_STATUS_READ:
            begin
                rd_byte = {7'd0, count_reg != '0};
            end
            ps2kc_pkg::KIND_DATA_READ:
            begin
                if (count_reg != '0)
                begin
                    pop            = 1'b1;
                    last_read_next = fifo_mem[head_reg];
                end
                rd_byte = last_read_next;
            end
            ps2kc_pkg::KIND_CMD_WRITE:
            begin
                await_config_next = 1'b0;
                case (req.write_byte)
                    ps2kc_pkg::CMD_READ_CONFIG:
                    begin
                        push_n       = 2'd1;
                        push_byte[0] = config_byte_reg;
                        push_byte[0][ps2kc_pkg::CFG_DUAL_BIT] = dual_channel_reg;
                    end
                    ps2kc_pkg::CMD_WRITE_CONFIG: await_config_next = 1'b1;
                    ps2kc_pkg::CMD_SELF_TEST:
                    begin
                        push_n       = 2'd1;
                        push_byte[0] = ps2kc_pkg::REPLY_CTRL_OK;
                    end
                    ps2kc_pkg::CMD_PORT1_TEST:
                    begin
                        push_n       = 2'd1;
                        push_byte[0] = ps2kc_pkg::REPLY_PORT_OK;
                    end
                    ps2kc_pkg::CMD_PORT1_OFF: port_en_next[0] = 1'b0;
                    ps2kc_pkg::CMD_PORT2_OFF: port_en_next[1] = 1'b0;
                    ps2kc_pkg::CMD_PORT1_ON:  port_en_next[0] = 1'b1;
                    default: ;
                endcase
            end
            default:
            begin
                if (await_config_reg)
                begin
                    config_byte_next  = req.write_byte;
                    await_config_next = 1'b0;
                end
                else if (port_en_reg[0])
                begin
                    push_byte[0] = ps2kc_pkg::REPLY_ACK;
                    case (req.write_byte)
                        ps2kc_pkg::KBD_RESET:
                        begin
                            push_n       = 2'd2;
                            push_byte[1] = ps2kc_pkg::REPLY_TEST_PASS;
                        end
                        ps2kc_pkg::KBD_SCAN_ON:
                        begin
                            push_n        = 2'd1;
                            scanning_next = 1'b1;
                        end
                        ps2kc_pkg::KBD_SCAN_OFF:
                        begin
                            push_n        = 2'd1;
                            scanning_next = 1'b0;
                        end
                        ps2kc_pkg::KBD_IDENTIFY:
                        begin
                            push_n       = 2'd3;
                            push_byte[1] = ps2kc_pkg::REPLY_ID_FIRST;
                            push_byte[2] = keyboard_id_reg;
                        end
                        default:
                        begin
                            push_n       = 2'd1;
                            push_byte[0] = ps2kc_pkg::REPLY_RESEND;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        logic [SUM_W-1:0] sum;
        sum    = '0;
        drop   = 1'b0;
        pushed = '0;
        for (int k = 0; k < NPUSH; k++)
        begin
            push_fits[k] = (SUM_W'(count_reg) + SUM_W'(k)) < SUM_W'(REPLY_DEPTH);
            sum = SUM_W'(head_reg) + SUM_W'(count_reg) + SUM_W'(k);
            if (sum >= SUM_W'(REPLY_DEPTH))
                sum = sum - SUM_W'(REPLY_DEPTH);
            push_idx[k] = sum[PTR_W-1:0];
            if (2'(k) < push_n)
            begin
                if (push_fits[k])
                    pushed = pushed + CNT_W'(1);
                else
                    drop = 1'b1;
            end
        end
        head_next = head_reg;
        if (pop)
            head_next = (head_reg == PTR_W'(REPLY_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        count_next = count_reg - CNT_W'(pop) + pushed;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NPUSH; k++)
        begin
            if (accept && 2'(k) < push_n && push_fits[k])
                fifo_mem[push_idx[k]] <= push_byte[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            count_reg        <= '0;
            last_read_reg    <= '0;
            config_byte_reg  <= ps2kc_pkg::CONFIG_BYTE_RST;
            await_config_reg <= 1'b0;
            port_en_reg      <= 2'b00;
            scanning_reg     <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg         <= head_next;
                count_reg        <= count_next;
                last_read_reg    <= last_read_next;
                config_byte_reg  <= config_byte_next;
                await_config_reg <= await_config_next;
                port_en_reg      <= port_en_next;
                scanning_reg     <= scanning_next;
                rsp_valid_reg    <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_byte_reg <= rd_byte;
            dropped_reg   <= drop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dual_channel_reg <= ps2kc_pkg::DUAL_CHANNEL_RST;
            keyboard_id_reg  <= ps2kc_pkg::KEYBOARD_ID_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ps2kc_pkg::CFG_DUAL_CHANNEL)
                dual_channel_reg <= cfg_data[0];
            if (cfg_index == ps2kc_pkg::CFG_KEYBOARD_ID)
                keyboard_id_reg <= cfg_data;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_byte = read_byte_reg;
    assign rsp.dropped   = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(REPLY_DEPTH))
        else $error("reply count beyond depth");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && dropped_reg |-> count_reg == CNT_W'(REPLY_DEPTH))
        else $error("byte dropped while queue not full");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == ps2kc_pkg::KIND_DATA_READ && count_reg != '0
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("data read did not release one entry");

    a_status_bit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.kind == ps2kc_pkg::KIND_STATUS_READ
        |=> read_byte_reg[0] == ($past(count_reg) != '0))
        else $error("status output-full bit wrong");

endmodule
